>>> hw/rtl/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix frame buffer package
// Command, action and register codes, the controller states and the
// structures passed between the controller and the blink timer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TIME_W     = 32;
   localparam int GEOM_W     = 5;
   localparam int TOTAL_W    = 2 * GEOM_W;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_FILL   = 2'd2;
   localparam logic [1:0] CMD_UPDATE = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_REDRAW = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_MATRIX_WIDTH   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATRIX_HEIGHT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLASH_ENABLE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLASH_ON_TIME  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLASH_OFF_TIME = 3'd4;

   localparam logic [GEOM_W-1:0] GEOM_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_ACCESS,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                  enable;
      logic [CSR_DATA_W-1:0] on_time;
      logic [CSR_DATA_W-1:0] off_time;
   } flash_cfg_type;

   typedef struct packed {
      logic              update;
      logic              dirty;
      logic [TIME_W-1:0] now_ms;
   } blink_req_type;

endpackage

>>> hw/rtl/lmfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lmfb_locate.sv
// ----------------------------------------------------------------------------
// Pixel locator
// Turns a pixel position into a store word and a bit within that word over
// three registered steps: linear position, word index by reciprocal
// multiplication, and bit offset as the remainder.
// ----------------------------------------------------------------------------
module lmfb_locate #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_HEIGHT = 16,
   parameter int WORD_BITS  = 8,
   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT,
   localparam int WORDS  = (PIXELS + WORD_BITS - 1) / WORD_BITS,
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1,
   localparam int BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
   input  logic          clock,
   input  logic          load,
   input  logic [7:0]    col_x,
   input  logic [7:0]    row_y,
   input  logic [4:0]    width,
   input  logic          divide,
   input  logic          split,
   output logic [AW-1:0] word_idx,
   output logic [BW-1:0] bit_idx
);

   localparam int PW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int LOG_WB = $clog2(WORD_BITS);
   localparam int SHIFT  = PW + LOG_WB;
   localparam int RW     = PW + 1;
   localparam int PRW    = PW + RW;
   localparam longint unsigned SCALE = 64'd1 << SHIFT;
   localparam longint unsigned RECIP = (SCALE + WORD_BITS - 1) / WORD_BITS;
   localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

   logic [15:0]    pos_calc;
   logic [PW-1:0]  pos_ff;
   logic [PW-1:0]  pos_in;
   logic [PRW-1:0] prod;
   logic [AW-1:0]  word_ff;
   logic [AW-1:0]  word_in;
   logic [BW-1:0]  bit_ff;
   logic [BW-1:0]  bit_in;

   always_comb begin
      pos_calc = 16'(row_y) * 16'(width) + 16'(col_x);
      pos_in   = pos_calc[PW-1:0];
      prod     = PRW'(pos_ff) * PRW'(RECIP_C);
      word_in  = AW'(prod >> SHIFT);
      bit_in   = BW'(pos_ff - PW'(word_ff * WORD_BITS));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= pos_in;
      end
      if (divide) begin
         word_ff <= word_in;
      end
      if (split) begin
         bit_ff <= bit_in;
      end
   end

   assign word_idx = word_ff;
   assign bit_idx  = bit_ff;

endmodule

>>> hw/rtl/lmfb_blink.sv
// ----------------------------------------------------------------------------
// Blink timer
// Holds the lit state and the time stamp of the last change, and decides the
// drawing action of an update from the elapsed time and the dirty mark.
// ----------------------------------------------------------------------------
module lmfb_blink import lmfb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  flash_cfg_type flash_cfg,
   input  logic          force_lit,
   input  blink_req_type blink_req,
   output logic [1:0]    action
);

   logic              lit_ff;
   logic              lit_in;
   logic [TIME_W-1:0] stamp_ff;
   logic [TIME_W-1:0] stamp_in;
   logic              lit_next;
   logic [TIME_W-1:0] stamp_next;
   logic [TIME_W-1:0] elapsed;

   always_comb begin
      elapsed    = blink_req.now_ms - stamp_ff;
      lit_next   = lit_ff;
      stamp_next = stamp_ff;
      action     = blink_req.dirty ? ACT_REDRAW : ACT_NONE;
      if (flash_cfg.enable) begin
         if (lit_ff && (elapsed > TIME_W'(flash_cfg.on_time))) begin
            lit_next   = 1'b0;
            stamp_next = blink_req.now_ms;
         end else if (!lit_ff && (elapsed > TIME_W'(flash_cfg.off_time))) begin
            action     = ACT_REDRAW;
            lit_next   = 1'b1;
            stamp_next = blink_req.now_ms;
         end
         if (!lit_next) begin
            action = ACT_CLEAR;
         end
      end
      lit_in   = lit_ff;
      stamp_in = stamp_ff;
      if (blink_req.update) begin
         lit_in   = lit_next;
         stamp_in = stamp_next;
      end
      if (force_lit) begin
         lit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff   <= 1'b1;
         stamp_ff <= '0;
      end else begin
         lit_ff   <= lit_in;
         stamp_ff <= stamp_in;
      end
   end

endmodule

>>> hw/rtl/led_matrix_framebuffer_flash.sv
// ----------------------------------------------------------------------------
// LED matrix frame buffer with blink timer
// A one-bit-per-pixel store held in a RAM of packed words, a dirty mark and
// a lit/dark blink timer, driven by write, read, fill and update commands.
//
// The request channel takes one command beat at a time; every request gives
// exactly one response beat. The configuration port writes width, height
// and the blink settings; the user must use it only while idle, as the
// block itself does not enforce it. An update and an out-of-range pixel
// access go straight to the response; a pixel write or read passes
// position, word divide, RAM read, modify and write back, and response;
// a fill reads and writes back each touched store word in turn. The next
// request is accepted in the cycle after the response is loaded; the rate
// is set by the single RAM port pair and the read-modify-write of one word.
// After reset the block zeroes the store, one word per cycle, all WORDS
// words (32 with the default parameters), before it accepts requests.
// When the receiver stalls, a finished response waits in the output
// register; the block takes the next request and holds its result until
// the output register is free.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_flash import lmfb_pkg::*; #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_HEIGHT = 16,
   parameter int WORD_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [7:0]            req_col_x,
   input  logic [7:0]            req_row_y,
   input  logic                  req_pixel_value,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pixel_out,
   output logic [1:0]            rsp_draw_action,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int WORDS  = (PIXELS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int SPAN_W = $clog2(WORDS * WORD_BITS + WORD_BITS + 1);
   localparam int BASE_W = (SPAN_W > TOTAL_W) ? SPAN_W : TOTAL_W;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

   state_type           state_ff;
   state_type           state_in;
   logic [GEOM_W-1:0]   width_ff;
   logic [GEOM_W-1:0]   width_in;
   logic [GEOM_W-1:0]   height_ff;
   logic [GEOM_W-1:0]   height_in;
   flash_cfg_type       flash_ff;
   flash_cfg_type       flash_in;
   logic                dirty_ff;
   logic                dirty_in;
   logic [AW-1:0]       word_ff;
   logic [AW-1:0]       word_in;
   logic [BASE_W-1:0]   base_ff;
   logic [BASE_W-1:0]   base_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic [1:0]          cmd_ff;
   logic [1:0]          cmd_in;
   logic                value_ff;
   logic                value_in;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   now_in;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic                pix_ff;
   logic                pix_in;
   logic                rsp_pixel_ff;
   logic                rsp_pixel_in;
   logic [1:0]          rsp_action_ff;
   logic [1:0]          rsp_action_in;

   logic [GEOM_W-1:0]   eff_width;
   logic [GEOM_W-1:0]   eff_height;
   logic                in_range;
   logic                accept;
   logic                loc_load;
   logic                loc_divide;
   logic                loc_split;
   logic [AW-1:0]       loc_word;
   logic [BW-1:0]       loc_bit;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic [WORD_BITS-1:0] fill_mask;
   logic [BASE_W-1:0]   base_next;
   logic                force_lit;
   blink_req_type       blink_req;
   logic [1:0]          blink_action;

   lmfb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lmfb_locate #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WORD_BITS  (WORD_BITS)
   ) u_locate (
      .clock    (clock),
      .load     (loc_load),
      .col_x    (req_col_x),
      .row_y    (req_row_y),
      .width    (eff_width),
      .divide   (loc_divide),
      .split    (loc_split),
      .word_idx (loc_word),
      .bit_idx  (loc_bit)
   );

   lmfb_blink u_blink (
      .clock     (clock),
      .reset     (reset),
      .flash_cfg (flash_ff),
      .force_lit (force_lit),
      .blink_req (blink_req),
      .action    (blink_action)
   );

   always_comb begin
      eff_width  = (int'(width_ff) > MAX_WIDTH) ? GEOM_W'(MAX_WIDTH) : width_ff;
      eff_height = (int'(height_ff) > MAX_HEIGHT) ? GEOM_W'(MAX_HEIGHT) : height_ff;
      in_range   = (8'(eff_width) > req_col_x) && (8'(eff_height) > req_row_y);
      base_next  = base_ff + BASE_W'(WORD_BITS);
      for (int b = 0; b < WORD_BITS; b++) begin
         fill_mask[b] = (base_ff + BASE_W'(b)) < BASE_W'(total_ff);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      flash_in  = flash_ff;
      force_lit = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MATRIX_WIDTH: begin
               width_in = csr_wdata[GEOM_W-1:0];
            end
            CSR_MATRIX_HEIGHT: begin
               height_in = csr_wdata[GEOM_W-1:0];
            end
            CSR_FLASH_ENABLE: begin
               flash_in.enable = csr_wdata[0];
               force_lit       = csr_wdata[0];
            end
            CSR_FLASH_ON_TIME: begin
               flash_in.on_time = csr_wdata;
            end
            CSR_FLASH_OFF_TIME: begin
               flash_in.off_time = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      dirty_in      = dirty_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      now_in        = now_ff;
      total_in      = total_ff;
      pix_in        = pix_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_action_in = rsp_action_ff;
      req_ready     = 1'b0;
      accept        = 1'b0;
      loc_load      = 1'b0;
      loc_divide    = 1'b0;
      loc_split     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = loc_word;
      blink_req     = '{update: 1'b0, dirty: dirty_ff, now_ms: now_ff};

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               loc_load = 1'b1;
               cmd_in   = req_command;
               value_in = req_pixel_value;
               now_in   = req_now_ms;
               total_in = TOTAL_W'(eff_width) * TOTAL_W'(eff_height);
               pix_in   = 1'b0;
               word_in  = '0;
               base_in  = '0;
               case (req_command)
                  CMD_UPDATE: begin
                     state_in = ST_FINISH;
                  end
                  CMD_FILL: begin
                     if (total_in == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        dirty_in = 1'b1;
                        state_in = ST_FILL_RD;
                     end
                  end
                  default: begin
                     state_in = in_range ? ST_DIV : ST_FINISH;
                  end
               endcase
            end
         end
         ST_DIV: begin
            loc_divide = 1'b1;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            loc_split = 1'b1;
            ram_rd_en = 1'b1;
            state_in  = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (cmd_ff == CMD_WRITE) begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = loc_word;
               ram_wr_data[loc_bit] = value_ff;
               dirty_in             = 1'b1;
            end else begin
               pix_in = ram_rd_data[loc_bit];
            end
            state_in = ST_FINISH;
         end
         ST_FILL_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = word_ff;
            state_in    = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (ram_rd_data & ~fill_mask) | (value_ff ? fill_mask : '0);
            if ((word_ff == LAST_WORD) || (base_next >= BASE_W'(total_ff))) begin
               state_in = ST_FINISH;
            end else begin
               word_in  = word_ff + AW'(1);
               base_in  = base_next;
               state_in = ST_FILL_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = (cmd_ff == CMD_READ) ? pix_ff : 1'b0;
               rsp_action_in = ACT_NONE;
               if (cmd_ff == CMD_UPDATE) begin
                  blink_req.update = 1'b1;
                  rsp_action_in    = blink_action;
                  if (blink_action == ACT_REDRAW) begin
                     dirty_in = 1'b0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= GEOM_RESET;
         height_ff    <= GEOM_RESET;
         flash_ff     <= '0;
         dirty_ff     <= 1'b0;
         word_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         flash_ff     <= flash_in;
         dirty_ff     <= dirty_in;
         word_ff      <= word_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      now_ff        <= now_in;
      total_ff      <= total_in;
      pix_ff        <= pix_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_action_ff <= rsp_action_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_draw_action = rsp_action_ff;

`ifndef SYNTHESIS
   a_one_field_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_draw_action != ACT_NONE)) |-> !rsp_pixel_out)
      else $error("Response carries both a pixel and a draw action.");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_draw_action == ACT_NONE || rsp_draw_action == ACT_REDRAW
                     || rsp_draw_action == ACT_CLEAR))
      else $error("Response draw action is not a defined code.");

   a_store_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_ACCESS
                     || state_ff == ST_FILL_WR))
      else $error("Store written outside a clear, access or fill step.");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid || rsp_ready)) |=>
      (rsp_valid && state_ff == ST_IDLE))
      else $error("Finished request did not reach the response register.");
`endif

endmodule
